@@ rtl/core/lkv_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by lkv_cell and lru_key_value_cache_unit.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // One stored line.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    // Update control broadcast to every cell.
    typedef struct packed {
        logic             upd;       // apply the move this cycle
        logic             miss_ins;  // set miss: insert at ins_pos
        logic [CNT_W-1:0] ins_pos;   // slot that the insert shifts into
    } t_ctl;

endpackage

@@ rtl/core/lkv_cell.sv @@
// One position of the recency-ordered chain; position 0 is most recent.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lkv_pkg::IDX_W-1:0]   i_idx,      // fixed position of this cell
    input  logic                        i_load,     // request accepted this cycle
    input  logic [lkv_pkg::KEY_W-1:0]   i_key,      // request key
    input  lkv_pkg::t_ctl               i_ctl,
    input  lkv_pkg::t_entry             i_prev,     // entry of the younger neighbor
    input  logic                        i_take_up,  // some older cell is the target
    output lkv_pkg::t_entry             o_entry,
    output logic                        o_take,     // this or an older cell is the target
    output logic                        o_hit,      // live compare
    output logic                        o_hit_q     // registered compare
);
    import lkv_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic             r_match;
    logic             w_mark;

    assign o_hit   = r_valid && (r_key == i_key);
    assign o_hit_q = r_match;
    assign o_entry.valid = r_valid;
    assign o_entry.key   = r_key;
    assign o_entry.value = r_value;

    assign w_mark = r_match || (i_ctl.miss_ins && (CNT_W'(i_idx) == i_ctl.ins_pos));
    assign o_take = w_mark || i_take_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_match <= o_hit;
            end
            if (i_ctl.upd && o_take) begin
                r_valid <= i_prev.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && o_take) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

endmodule

@@ rtl/core/lru_key_value_cache_unit.sv @@
// LRU key-value cache: one transaction in flight.
// Accept (idle state): all cells compare the key; the hit value is captured.
// Update state: the chain shifts (except on a get miss) and a get result loads the
// output register; a get stays in the update state while an older result is undrained.
// A new transaction is accepted while a result waits in the output register.
// Synchronous active-low reset: all entries invalid, count 0, capacity 16.
`timescale 1ns / 1ps

module lru_key_value_cache_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]  s_axis_tuser,   // [0] req_type (0 get, 1 set)
    // get result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] read_value
    output logic [0:0]  m_axis_tuser,   // [0] found
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lkv_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_UPD  = 2'b10
    } t_state;

    t_state r_state, n_state;

    // capacity register, the only one (byte address 0)
    logic [CAP_W-1:0] r_cap;
    logic             w_cfg_wr;

    // captured request
    logic             r_req;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] r_hit_val;
    logic [CNT_W-1:0] r_count;

    // output register
    logic             r_out_valid;
    logic             r_found;
    logic [VAL_W-1:0] r_rdata;

    // chain wiring
    t_entry           w_entry [ENTRIES];
    t_entry           w_prev  [ENTRIES];
    t_entry           w_new;
    logic [ENTRIES:0] w_take;
    logic [ENTRIES-1:0] w_hit_c;
    logic [ENTRIES-1:0] w_hit_q;
    logic [VAL_W-1:0] w_hit_val;
    t_ctl             w_ctl;

    logic             w_accept;
    logic             w_hit;
    logic             w_full;
    logic             w_slot_free;
    logic             w_advance;
    logic [CNT_W-1:0] w_eff_cap;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {{(32-CAP_W){1'b0}}, r_cap} : '0;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // capacity zero acts as one, above ENTRIES as ENTRIES
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CNT_W'(1);
        end else if ({{(32-CAP_W){1'b0}}, r_cap} > 32'(ENTRIES)) begin
            w_eff_cap = CNT_W'(ENTRIES);
        end else begin
            w_eff_cap = CNT_W'(r_cap);
        end
    end

    assign w_hit  = |w_hit_q;
    assign w_full = (r_count >= w_eff_cap);

    // result slot is free when empty or drained this cycle
    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_advance   = (r_state == ST_UPD) && ((r_req == REQ_SET) || w_slot_free);

    // a get miss leaves the chain untouched
    always_comb begin
        w_ctl.upd      = w_advance && ((r_req == REQ_SET) || w_hit);
        w_ctl.miss_ins = (r_req == REQ_SET) && !w_hit;
        w_ctl.ins_pos  = w_full ? (r_count - CNT_W'(1)) : r_count;
    end

    // new most-recent entry enters at position 0
    assign w_new.valid = 1'b1;
    assign w_new.key   = r_key;
    assign w_new.value = (r_req == REQ_SET) ? r_val : r_hit_val;

    // hit value: keys are unique, so at most one term is live
    always_comb begin
        w_hit_val = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            w_hit_val = w_hit_val | ({VAL_W{w_hit_c[k]}} & w_entry[k].value);
        end
    end

    assign w_take[ENTRIES] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = w_new;
        end else begin : g_body
            assign w_prev[g] = w_entry[g-1];
        end

        lkv_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (IDX_W'(g)),
            .i_load    (w_accept),
            .i_key     (s_axis_tdata[KEY_W-1:0]),
            .i_ctl     (w_ctl),
            .i_prev    (w_prev[g]),
            .i_take_up (w_take[g+1]),
            .o_entry   (w_entry[g]),
            .o_take    (w_take[g]),
            .o_hit     (w_hit_c[g]),
            .o_hit_q   (w_hit_q[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (w_advance) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_cap <= pwdata[CAP_W-1:0];
            end
            // count grows only when an insert lands in a free slot
            if (w_ctl.upd && w_ctl.miss_ins && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_advance && (r_req == REQ_GET)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req     <= s_axis_tuser[0];
            r_key     <= s_axis_tdata[KEY_W-1:0];
            r_val     <= s_axis_tdata[KEY_W +: VAL_W];
            r_hit_val <= w_hit_val;
        end
        if (w_advance && (r_req == REQ_GET)) begin
            r_found <= w_hit;
            r_rdata <= w_hit ? r_hit_val : '1;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_rdata;
    assign m_axis_tuser[0] = r_found;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    logic [ENTRIES-1:0] w_valid_vec;
    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            w_valid_vec[k] = w_entry[k].valid;
        end
    end

    // keys stay unique, so a lookup matches at most one line
    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit_q))
        else $error("lookup matched more than one line");

    // occupied lines track the entry count
    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == 32'(r_count))
        else $error("entry count disagrees with valid lines");

    // count never exceeds the line count
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ENTRIES)
        else $error("entry count overflow");

    // a result appears only after an update cycle for a get
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && (r_req == REQ_GET)))
        else $error("result without a completed get");

endmodule
